/* hdl/lsw_pkg.sv */
// Shared types, constants and the Laplacian window sum for the saliency weight map.
`default_nettype none

package lsw_pkg;

   localparam int PIX_W      = 8;
   localparam int DIM_W      = 11;
   localparam int ROW_W      = 12;
   localparam int SUM_W      = 13;
   localparam int MAG_W      = 12;
   localparam int PAIR_W     = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam logic OP_PIXEL = 1'b0;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;
   localparam logic [DIM_W-1:0] DIM_MIN      = 11'd3;

   // window indexed [column][row], column 0 left, row 0 top
   typedef logic [2:0][2:0][PIX_W-1:0] win_type;

   typedef struct packed {
      logic              load;
      logic              emit;
      logic              use_pre;
      logic              slot;
      logic              real_pix;
      logic              left;
      logic              right;
      logic              top;
      logic              bottom;
      logic              last;
      logic [PAIR_W-1:0] pix;
   } step_type;

   function automatic logic signed [SUM_W-1:0] lap_sum(input win_type px,
                                                       input logic lft,
                                                       input logic rgt,
                                                       input logic tp,
                                                       input logic bt);
      logic [SUM_W-2:0] acc;
      logic [SUM_W-1:0] ctr9;
      int               dr;
      int               dc;
      int               cs;
      int               rs;
      acc = '0;
      for (dr = 0; dr < 3; dr++) begin
         for (dc = 0; dc < 3; dc++) begin
            cs = dc;
            rs = dr;
            if (dc == 0 && lft) cs = 2;
            if (dc == 2 && rgt) cs = 0;
            if (dr == 0 && tp) rs = 2;
            if (dr == 2 && bt) rs = 0;
            acc = acc + (SUM_W-1)'(px[cs][rs]);
         end
      end
      ctr9 = {2'b00, px[1][1], 3'b000} + SUM_W'(px[1][1]);
      return $signed({1'b0, acc}) - $signed(ctr9);
   endfunction

endpackage

`default_nettype wire

/* hdl/lsw_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read-first output.
`default_nettype none

module lsw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/lsw_ctrl.sv */
// Frame position, flush drain, configuration registers and line store addressing.
`default_nettype none

module lsw_ctrl #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic                               req_op,
   input  wire logic [lsw_pkg::PAIR_W-1:0]         req_pair,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [lsw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lsw_pkg::DIM_W-1:0]          csr_data,
   input  wire logic                               c_emit,
   input  wire logic [lsw_pkg::FIFO_CNT_W-1:0]     fifo_level,
   output logic                                    ram_rd_en,
   output logic [AW-1:0]                           ram_addr,
   output logic [1:0]                              ram_wr_en,
   output lsw_pkg::step_type                       step
);

   import lsw_pkg::*;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
      logic [DIM_W-1:0] res;
      res = v;
      if (v < DIM_MIN) res = DIM_MIN;
      else if (int'(v) > hi) res = DIM_W'(hi);
      return res;
   endfunction

   logic [DIM_W-1:0] w_ff, w_in, h_ff, h_in;
   logic [ROW_W-1:0] row_ff, row_in, pend_ff, pend_in;
   logic [DIM_W-1:0] col_ff, col_in;
   step_type         step_ff, step_in;

   logic             accept, is_pix, restart, advance, c_zero;
   logic [ROW_W-1:0] r0, row_adv, cr, h_ext;
   logic [DIM_W-1:0] c0, col_adv, cc;
   logic [ROW_W-1:0] col_inc;

   always_comb begin
      h_ext   = {1'b0, h_ff};
      accept  = req_tvalid & req_tready;
      is_pix  = (req_op == OP_PIXEL);
      restart = is_pix && ((row_ff >= h_ext) || (col_ff >= w_ff));
      r0      = restart ? '0 : row_ff;
      c0      = restart ? '0 : col_ff;
      advance = accept && (is_pix || (pend_ff != '0));
      c_zero  = (c0 == '0);
      col_inc = ROW_W'(c0) + 12'd1;
      if (col_inc >= {1'b0, w_ff}) begin
         col_adv = '0;
         row_adv = r0 + 12'd1;
      end else begin
         col_adv = DIM_W'(col_inc);
         row_adv = r0;
      end

      w_in    = w_ff;
      h_in    = h_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      pend_in = pend_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               w_in = clamp_dim(csr_data, MAX_WIDTH);
            end
            REG_FRAME_HEIGHT: begin
               h_in = clamp_dim(csr_data, MAX_HEIGHT);
            end
            default: begin
            end
         endcase
         row_in  = '0;
         col_in  = '0;
         pend_in = '0;
      end else if (advance) begin
         if (is_pix) begin
            row_in  = row_adv;
            col_in  = col_adv;
            pend_in = (row_adv == h_ext) ? (ROW_W'(w_ff) + 12'd1) : '0;
         end else begin
            pend_in = pend_ff - 12'd1;
            if (pend_ff == 12'd1) begin
               row_in = '0;
               col_in = '0;
            end else begin
               row_in = row_adv;
               col_in = col_adv;
            end
         end
      end

      cr = c_zero ? (r0 - 12'd2) : (r0 - 12'd1);
      cc = c_zero ? (w_ff - 11'd1) : (c0 - 11'd1);
      step_in.load     = advance && (c_zero ? (r0 <= h_ext) : 1'b1);
      step_in.emit     = advance && (c_zero ? (r0 >= 12'd2) : (r0 >= 12'd1));
      step_in.use_pre  = c_zero;
      step_in.slot     = r0[0];
      step_in.real_pix = is_pix;
      step_in.left     = (cc == '0);
      step_in.right    = (cc == (w_ff - 11'd1));
      step_in.top      = (cr == '0);
      step_in.bottom   = (cr == (h_ext - 12'd1));
      step_in.last     = step_in.right && step_in.bottom;
      step_in.pix      = req_pair;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff    <= clamp_dim(WIDTH_RESET, MAX_WIDTH);
         h_ff    <= clamp_dim(HEIGHT_RESET, MAX_HEIGHT);
         row_ff  <= '0;
         col_ff  <= '0;
         pend_ff <= '0;
         step_ff <= '0;
      end else begin
         w_ff    <= w_in;
         h_ff    <= h_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         pend_ff <= pend_in;
         step_ff <= step_in;
      end
   end

   assign req_tready   = (FIFO_CNT_W'(fifo_level) + FIFO_CNT_W'(step_ff.emit)
                          + FIFO_CNT_W'(c_emit)) < FIFO_CNT_W'(FIFO_DEPTH);
   assign csr_ready    = 1'b1;
   assign ram_rd_en    = advance;
   assign ram_addr     = AW'(c0);
   assign ram_wr_en[0] = advance & is_pix & ~r0[0];
   assign ram_wr_en[1] = advance & is_pix & r0[0];
   assign step         = step_ff;

endmodule

`default_nettype wire

/* hdl/lsw_window.sv */
// 3x3 window registers for both images and the signed Laplacian sums.
`default_nettype none

module lsw_window (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lsw_pkg::step_type                 step,
   input  wire logic [lsw_pkg::PAIR_W-1:0]        rd_data0,
   input  wire logic [lsw_pkg::PAIR_W-1:0]        rd_data1,
   output logic                                   c_emit,
   output logic                                   c_last,
   output logic signed [lsw_pkg::SUM_W-1:0]       c_front_sum,
   output logic signed [lsw_pkg::SUM_W-1:0]       c_back_sum
);

   import lsw_pkg::*;

   win_type front_win_ff, front_win_in, back_win_ff, back_win_in;
   win_type front_use, back_use;
   logic [PAIR_W-1:0] top_pair, mid_pair, bot_pair;

   logic                     emit_ff, last_ff;
   logic signed [SUM_W-1:0]  front_sum_ff, back_sum_ff;

   always_comb begin
      top_pair = step.slot ? rd_data1 : rd_data0;
      mid_pair = step.slot ? rd_data0 : rd_data1;
      bot_pair = step.real_pix ? step.pix : top_pair;

      front_win_in = front_win_ff;
      back_win_in  = back_win_ff;
      if (step.load) begin
         front_win_in[0] = front_win_ff[1];
         front_win_in[1] = front_win_ff[2];
         front_win_in[2] = {bot_pair[15:8], mid_pair[15:8], top_pair[15:8]};
         back_win_in[0]  = back_win_ff[1];
         back_win_in[1]  = back_win_ff[2];
         back_win_in[2]  = {bot_pair[7:0], mid_pair[7:0], top_pair[7:0]};
      end
      front_use = step.use_pre ? front_win_ff : front_win_in;
      back_use  = step.use_pre ? back_win_ff : back_win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_win_ff <= '0;
         back_win_ff  <= '0;
         emit_ff      <= 1'b0;
      end else begin
         front_win_ff <= front_win_in;
         back_win_ff  <= back_win_in;
         emit_ff      <= step.emit;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= step.last;
      front_sum_ff <= lap_sum(front_use, step.left, step.right, step.top, step.bottom);
      back_sum_ff  <= lap_sum(back_use, step.left, step.right, step.top, step.bottom);
   end

   assign c_emit      = emit_ff;
   assign c_last      = last_ff;
   assign c_front_sum = front_sum_ff;
   assign c_back_sum  = back_sum_ff;

endmodule

`default_nettype wire

/* hdl/lsw_out.sv */
// Magnitudes, front weight select and the result queue.
`default_nettype none

module lsw_out (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              c_emit,
   input  wire logic                              c_last,
   input  wire logic signed [lsw_pkg::SUM_W-1:0]  c_front_sum,
   input  wire logic signed [lsw_pkg::SUM_W-1:0]  c_back_sum,
   output logic [lsw_pkg::FIFO_CNT_W-1:0]         fifo_level,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [lsw_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tlast
);

   import lsw_pkg::*;

   logic [MAG_W-1:0]      front_mag, back_mag;
   logic                  front_wins, push, pop;
   logic [RSP_DATA_W-1:0] entry;

   logic [RSP_DATA_W-1:0] queue_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      front_mag  = c_front_sum[SUM_W-1] ? MAG_W'(-c_front_sum) : MAG_W'(c_front_sum);
      back_mag   = c_back_sum[SUM_W-1] ? MAG_W'(-c_back_sum) : MAG_W'(c_back_sum);
      front_wins = (back_mag <= front_mag);
      entry      = {c_last, back_mag[10:0], front_mag[10:0], front_wins};
      push       = c_emit;
      pop        = rsp_tvalid & rsp_tready;
      count_in   = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   assign fifo_level = count_ff;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {1'b0, queue_ff[rd_ptr_ff][RSP_DATA_W-2:0]};
   assign rsp_tlast  = queue_ff[rd_ptr_ff][RSP_DATA_W-1];

endmodule

`default_nettype wire

/* hdl/laplacian_saliency_weight_map_top.sv */
// Top level of the 3x3 Laplacian saliency weight map for two co-registered images.
//
//   Channel | Direction | Transaction
//   req_    | in        | one pixel pair or one flush
//   rsp_    | out       | one result: magnitudes, front weight select, end of frame
//   csr_    | in        | one register write: frame_width (0), frame_height (1)
//
// One request is taken per cycle while req_tready is high; a result leaves through the
// registered line store read, the registered window sum, then magnitude and queue.
// Throughput is set by the single read-first access per cycle to each line store bank.
// Synchronous reset; the line stores are not cleared and need no sweep.
// req_tready drops only when the four-entry result queue could overflow.
`default_nettype none

module laplacian_saliency_weight_map_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [lsw_pkg::REQ_DATA_W-1:0]     req_tdata,   // front_pixel, back_pixel
   input  wire logic                               req_tuser,   // op
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [lsw_pkg::RSP_DATA_W-1:0]          rsp_tdata,   // front_wins, front_magnitude,
                                                                // back_magnitude, zero pad
   output logic                                    rsp_tlast,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [lsw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lsw_pkg::DIM_W-1:0]          csr_data
);

   import lsw_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic                     ram_rd_en;
   logic [AW-1:0]            ram_addr;
   logic [1:0]               ram_wr_en;
   logic [PAIR_W-1:0]        rd_data0, rd_data1, wr_pair;
   step_type                 step;
   logic                     c_emit, c_last;
   logic signed [SUM_W-1:0]  c_front_sum, c_back_sum;
   logic [FIFO_CNT_W-1:0]    fifo_level;

   // stored pair: front in the high byte, back in the low byte
   assign wr_pair = {req_tdata[7:0], req_tdata[15:8]};

   lsw_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_pair   (wr_pair),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .c_emit     (c_emit),
      .fifo_level (fifo_level),
      .ram_rd_en  (ram_rd_en),
      .ram_addr   (ram_addr),
      .ram_wr_en  (ram_wr_en),
      .step       (step)
   );

   lsw_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (MAX_WIDTH)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (ram_wr_en[0]),
      .wr_addr (ram_addr),
      .wr_data (wr_pair),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (rd_data0)
   );

   lsw_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (MAX_WIDTH)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (ram_wr_en[1]),
      .wr_addr (ram_addr),
      .wr_data (wr_pair),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (rd_data1)
   );

   lsw_window u_window (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rd_data0    (rd_data0),
      .rd_data1    (rd_data1),
      .c_emit      (c_emit),
      .c_last      (c_last),
      .c_front_sum (c_front_sum),
      .c_back_sum  (c_back_sum)
   );

   lsw_out u_out (
      .clock       (clock),
      .reset       (reset),
      .c_emit      (c_emit),
      .c_last      (c_last),
      .c_front_sum (c_front_sum),
      .c_back_sum  (c_back_sum),
      .fifo_level  (fifo_level),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

/* verif/tb_laplacian_saliency_weight_map_top.sv */
// Self-checking testbench for the Laplacian saliency weight map top level.
`default_nettype none

module tb_laplacian_saliency_weight_map_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lsw_pkg::*;

   localparam int   MAX_W         = 1024;
   localparam int   MAX_H         = 1024;
   localparam logic OP_FLUSH      = ~OP_PIXEL;
   localparam int   IDLE_LIMIT    = 3000;
   localparam int   SETTLE_CYCLES = 8;
   localparam int   RANDOM_ITEMS  = 750;
   localparam int   MAX_REPORTS   = 10;

   typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_SMOOTH} pixel_style_type;

   typedef struct packed {
      logic             wins;
      logic [DIM_W-1:0] front_mag;
      logic [DIM_W-1:0] back_mag;
      logic             last;
   } weight_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // front_pixel, back_pixel
   logic                  req_tuser  = 1'b0; // op
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // front_wins, front_magnitude, back_magnitude, pad
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [DIM_W-1:0]      csr_data   = '0;

   logic [DIM_W-1:0]  width_reg;
   logic [DIM_W-1:0]  height_reg;
   logic [PAIR_W-1:0] line_pairs [2][MAX_W];
   logic [PIX_W-1:0]  window_px [18];
   int unsigned       row_pos;
   int unsigned       col_pos;
   int unsigned       drain_left;
   weight_result_type expected_weights [$];

   int mismatch_count = 0;
   int useful_items   = 0;
   int hold_request   = 0;
   int idle_cycles    = 0;
   bit steady         = 1'b0;

   weight_result_type got;
   weight_result_type want;

   laplacian_saliency_weight_map_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned clamped_dim(input logic [DIM_W-1:0] v,
                                               input int unsigned hi);
      int unsigned d;
      d = v;
      if (d < 3) d = 3;
      if (d > hi) d = hi;
      return d;
   endfunction

   function automatic int unsigned eff_width();
      return clamped_dim(width_reg, MAX_W);
   endfunction

   function automatic int unsigned eff_height();
      return clamped_dim(height_reg, MAX_H);
   endfunction

   function automatic int unsigned laplace_mag(input int img, input int unsigned cr, cc, w, h);
      int sum;
      int dr;
      int dc;
      int cs;
      int rs;
      sum = 0;
      for (dr = 0; dr < 3; dr++) begin
         for (dc = 0; dc < 3; dc++) begin
            cs = dc;
            rs = dr;
            if (dc == 0 && cc == 0) cs = 2;
            if (dc == 2 && cc == w - 1) cs = 0;
            if (dr == 0 && cr == 0) rs = 2;
            if (dr == 2 && cr == h - 1) rs = 0;
            sum += int'(window_px[(cs * 3 + rs) * 2 + img]);
         end
      end
      sum -= 9 * int'(window_px[8 + img]);
      if (sum < 0) sum = -sum;
      return sum;
   endfunction

   function automatic void predict_emit(input int unsigned cr, cc, w, h);
      weight_result_type r;
      int unsigned       fm;
      int unsigned       bm;
      fm          = laplace_mag(0, cr, cc, w, h);
      bm          = laplace_mag(1, cr, cc, w, h);
      r.wins      = (bm <= fm);
      r.front_mag = DIM_W'(fm);
      r.back_mag  = DIM_W'(bm);
      r.last      = (cr == h - 1 && cc == w - 1);
      expected_weights.insert(expected_weights.size(), r);
   endfunction

   function automatic void shift_column(input int unsigned r, c, input logic is_pixel,
                                        input logic [PIX_W-1:0] fr, bk);
      logic              slot;
      logic [PAIR_W-1:0] top_pair;
      logic [PAIR_W-1:0] mid_pair;
      logic [PAIR_W-1:0] bot_pair;
      int                i;
      slot     = r[0];
      top_pair = line_pairs[slot][c];
      mid_pair = line_pairs[~slot][c];
      bot_pair = is_pixel ? {fr, bk} : top_pair;
      if (is_pixel) line_pairs[slot][c] = bot_pair;
      for (i = 0; i < 12; i++) window_px[i] = window_px[i + 6];
      window_px[12] = top_pair[15:8];
      window_px[13] = top_pair[7:0];
      window_px[14] = mid_pair[15:8];
      window_px[15] = mid_pair[7:0];
      window_px[16] = bot_pair[15:8];
      window_px[17] = bot_pair[7:0];
   endfunction

   function automatic void advance_position(input logic is_pixel, input logic [PIX_W-1:0] fr, bk,
                                            input int unsigned w, h);
      int unsigned r;
      int unsigned c;
      r = row_pos;
      c = col_pos;
      if (c == 0) begin
         if (r >= 2) predict_emit(r - 2, w - 1, w, h);
         if (r <= h) shift_column(r, c, is_pixel, fr, bk);
      end else begin
         shift_column(r, c, is_pixel, fr, bk);
         if (r >= 1) predict_emit(r - 1, c - 1, w, h);
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
      end
   endfunction

   function automatic void predict_item(input logic op, input logic [PIX_W-1:0] fr, bk);
      int unsigned w;
      int unsigned h;
      w = eff_width();
      h = eff_height();
      if (op == OP_PIXEL) begin
         if (row_pos >= h || col_pos >= w) begin
            row_pos    = 0;
            col_pos    = 0;
            drain_left = 0;
         end
         advance_position(1'b1, fr, bk, w, h);
         if (row_pos == h) drain_left = w + 1;
      end else if (drain_left != 0) begin
         advance_position(1'b0, '0, '0, w, h);
         drain_left--;
         if (drain_left == 0) begin
            row_pos = 0;
            col_pos = 0;
         end
      end
   endfunction

   function automatic void predict_config(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [DIM_W-1:0] val);
      case (idx)
         REG_FRAME_WIDTH: width_reg = val;
         REG_FRAME_HEIGHT: height_reg = val;
         default: ;
      endcase
      row_pos    = 0;
      col_pos    = 0;
      drain_left = 0;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [PIX_W-1:0] pixel_value(input pixel_style_type style);
      case (style)
         PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         PIX_SMOOTH: return PIX_W'(120 + $urandom_range(0, 6));
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim(input int unsigned hi);
      if ($urandom_range(0, 99) < 8) return DIM_W'($urandom_range(0, 2));
      return DIM_W'($urandom_range(3, hi));
   endfunction

   function automatic void report_mismatch(input string what, input weight_result_type exp_r,
                                           input weight_result_type act_r);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t %s: expected wins=%0d front=%0d back=%0d last=%0d,",
                  $time, what, exp_r.wins, exp_r.front_mag, exp_r.back_mag, exp_r.last,
                  " got wins=%0d front=%0d back=%0d last=%0d",
                  act_r.wins, act_r.front_mag, act_r.back_mag, act_r.last);
   endfunction

   task automatic send_item(input logic op, input logic [PIX_W-1:0] fr, bk);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {bk, fr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_PIXEL || drain_left != 0) useful_items++;
      predict_item(op, fr, bk);
   endtask

   task automatic send_pixels(input int unsigned count, input pixel_style_type style,
                              input int noise_pct);
      int unsigned i;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_item(OP_FLUSH, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)));
         send_item(OP_PIXEL, pixel_value(style), pixel_value(style));
      end
   endtask

   task automatic send_flushes(input int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++)
         send_item(OP_FLUSH, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)));
   endtask

   task automatic send_frame(input pixel_style_type style, input int noise_pct);
      send_pixels(eff_width() * eff_height(), style, noise_pct);
      send_flushes(eff_width() + 1);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_weights.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      predict_config(idx, val);
   endtask

   task automatic test_small_frame_edges();
      int i;
      write_reg(REG_FRAME_WIDTH, 11'd3);
      write_reg(REG_FRAME_HEIGHT, 11'd3);
      send_item(OP_FLUSH, 8'hFF, 8'hFF);
      for (i = 0; i < 9; i++) begin
         send_item(OP_PIXEL, (i == 4) ? 8'hFF : 8'h00, (i == 4) ? 8'h00 : 8'hFF);
         if (i == 4) send_item(OP_FLUSH, 8'h00, 8'h00);
      end
      // abandon the drain: the next pixel opens a new frame
      send_flushes(2);
      send_pixels(9, PIX_RANDOM, 0);
      send_flushes(5);
   endtask

   task automatic test_dimension_limits();
      write_reg(REG_FRAME_WIDTH, 11'd0);
      write_reg(REG_FRAME_HEIGHT, 11'd0);
      send_frame(PIX_RANDOM, 0);
      write_reg(REG_FRAME_WIDTH, 11'd3);
      write_reg(REG_FRAME_HEIGHT, 11'd2047);
      send_pixels(15, PIX_EXTREME, 0);
      write_reg(REG_FRAME_WIDTH, 11'd1500);
      write_reg(REG_FRAME_HEIGHT, 11'd1024);
      send_pixels(1030, PIX_RANDOM, 0);
   endtask

   task automatic test_backpressure();
      write_reg(REG_FRAME_WIDTH, 11'd10);
      write_reg(REG_FRAME_HEIGHT, 11'd5);
      steady       = 1'b1;
      hold_request = 150;
      send_frame(PIX_RANDOM, 0);
      steady = 1'b0;
   endtask

   task automatic test_random_frames();
      pixel_style_type style;
      int              kind;
      int unsigned     w;
      int unsigned     h;
      useful_items = 0;
      while (useful_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 30) begin
            if ($urandom_range(0, 2) != 0)
               write_reg(REG_FRAME_WIDTH, pick_dim(($urandom_range(0, 3) == 0) ? 40 : 12));
            if ($urandom_range(0, 2) != 0)
               write_reg(REG_FRAME_HEIGHT, pick_dim(8));
         end
         steady = ($urandom_range(0, 99) < 15);
         style  = pixel_style_type'($urandom_range(0, 2));
         kind   = $urandom_range(0, 99);
         w      = eff_width();
         h      = eff_height();
         if (kind < 75) begin
            send_pixels(w * h, style, 5);
            send_flushes(w + 1 + $urandom_range(0, 2));
         end else if (kind < 88) begin
            send_pixels(w * h, style, 5);
            send_flushes($urandom_range(0, w));
         end else begin
            // restart mid-frame with a register write
            send_pixels($urandom_range(1, w * h - 1), style, 5);
            if ($urandom_range(0, 1))
               write_reg(REG_FRAME_WIDTH, width_reg);
            else
               write_reg(REG_FRAME_HEIGHT, height_reg);
         end
      end
      steady = 1'b0;
   endtask

   initial begin : receiver
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.wins      = rsp_tdata[0];
         got.front_mag = rsp_tdata[11:1];
         got.back_mag  = rsp_tdata[22:12];
         got.last      = rsp_tlast;
         if (expected_weights.size() == 0) begin
            report_mismatch("result with none expected", '0, got);
         end else begin
            want = expected_weights.pop_front();
            if (got.wins !== want.wins || got.front_mag !== want.front_mag ||
                got.back_mag !== want.back_mag || got.last !== want.last)
               report_mismatch("result mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int s;
      int c;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      row_pos    = 0;
      col_pos    = 0;
      drain_left = 0;
      for (s = 0; s < 2; s++)
         for (c = 0; c < MAX_W; c++) line_pairs[s][c] = '0;
      for (c = 0; c < 18; c++) window_px[c] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_small_frame_edges();
      test_dimension_limits();
      test_backpressure();
      test_random_frames();
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_weights.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
